// File: design/baro_comp_pkg.sv
// ============================================================================
// Barometric compensation package
// Shared types and constants for the pressure and temperature compensation
// core: the calibration word set, register indexes and fixed limits.
// ============================================================================
package baro_comp_pkg;

  // Widths of the streaming payloads.
  localparam int RAW_W  = 24;
  localparam int TEMP_W = 20;
  localparam int PRES_W = 28;
  localparam int CAL_W  = 16;

  // Number of register stages in the compensation pipeline.
  localparam int NSTG = 10;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } reg_idx_t;

  // Factory calibration word set.
  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } calib_t;

  // Temperature break points in centidegrees (20.00 C and -15.00 C).
  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [18:0] TEMP_VLOW = -19'sd1500;

  // Distance of the low break point below the reference, on the 18-bit
  // first-order difference, and the bias that turns that difference into
  // the temperature relative to the low break point.
  localparam logic signed [17:0] X_VLOW    = 18'(TEMP_VLOW) - 18'(TEMP_REF);
  localparam logic signed [18:0] VLOW_BIAS = 19'(TEMP_REF) - TEMP_VLOW;

  // Saturation limits of the pressure result.
  localparam logic [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
  localparam logic [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

endpackage

// File: design/baro_comp_regs.sv
// ============================================================================
// Barometric compensation calibration registers
// Holds the six 16-bit factory calibration words written over the
// configuration port. Unknown indexes are ignored.
// ============================================================================
module baro_comp_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [2:0]                          wr_index,
  input  logic [baro_comp_pkg::CAL_W-1:0]     wr_data,
  output baro_comp_pkg::calib_t               calib
);

  baro_comp_pkg::calib_t cal_r;
  baro_comp_pkg::calib_t cal_nxt;

  // Decode the register index of a write request.
  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      unique case (wr_index)
        baro_comp_pkg::REG_PRESSURE_SENSITIVITY:   cal_nxt.pressure_sensitivity   = wr_data;
        baro_comp_pkg::REG_PRESSURE_OFFSET:        cal_nxt.pressure_offset        = wr_data;
        baro_comp_pkg::REG_SENSITIVITY_TEMP_COEFF: cal_nxt.sensitivity_temp_coeff = wr_data;
        baro_comp_pkg::REG_OFFSET_TEMP_COEFF:      cal_nxt.offset_temp_coeff      = wr_data;
        baro_comp_pkg::REG_REFERENCE_TEMPERATURE:  cal_nxt.reference_temperature  = wr_data;
        baro_comp_pkg::REG_TEMPERATURE_COEFF:      cal_nxt.temperature_coeff      = wr_data;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  // Calibration words reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign calib = cal_r;

endmodule

// File: design/baro_pressure_temp_compensation_core.sv
// ============================================================================
// Barometric pressure and temperature compensation core
// Ten-stage pipeline that turns raw temperature and pressure conversions
// into compensated temperature and pressure with second-order correction.
// ============================================================================
// Usage:
//   The in_ stream carries one raw temperature and raw pressure pair per
//   request; the out_ stream returns one compensated temperature and
//   pressure pair per request, in order. The cfg_ channel writes the six
//   calibration words by index; it is always ready and should be used only
//   while no request is in flight.
//   The pipeline accepts one request per cycle while the receiver does not
//   stall it; each request passes through the ten register stages in order.
//   The final stage is an output register. When the receiver stalls, each
//   stage holds its item and in_tready stays high as long as some stage
//   ahead of the stall is empty, so bubbles are squeezed out.
//   Synchronous reset empties the pipeline and clears the calibration
//   words to zero.
// ============================================================================
module baro_pressure_temp_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: [23:0] raw_temperature, [47:24] raw_pressure.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // Output stream: [19:0] temperature_centideg, [47:20] pressure_pascal.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  baro_comp_pkg::calib_t cal;

  logic [baro_comp_pkg::NSTG:1] vld_r;
  logic [baro_comp_pkg::NSTG+1:1] rdy;

  // Calibration registers.
  assign cfg_ready = 1'b1;

  baro_comp_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .calib    (cal)
  );

  // Stage enables: a stage loads when it is empty or its successor loads.
  assign rdy[baro_comp_pkg::NSTG+1] = out_tready;
  for (genvar k = 1; k <= baro_comp_pkg::NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign in_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= baro_comp_pkg::NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: temperature difference against the reference.
  logic signed [24:0] dt_r, dt_nxt;
  logic [23:0]        d1_s1_r;

  assign dt_nxt = $signed({1'b0, in_tdata[23:0]})
                - $signed({1'b0, cal.reference_temperature, 8'b0});

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= in_tdata[47:24];
    end
  end

  // Stage 2: products of the difference with the coefficients and itself.
  logic signed [41:0] psens_r, psens_nxt;
  logic signed [41:0] poff_r, poff_nxt;
  logic signed [41:0] ptemp_r, ptemp_nxt;
  logic signed [49:0] psq_r, psq_nxt;
  logic [23:0]        d1_s2_r;

  assign psens_nxt = $signed({1'b0, cal.sensitivity_temp_coeff}) * dt_r;
  assign poff_nxt  = $signed({1'b0, cal.offset_temp_coeff}) * dt_r;
  assign ptemp_nxt = $signed({1'b0, cal.temperature_coeff}) * dt_r;
  assign psq_nxt   = dt_r * dt_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      psens_r <= psens_nxt;
      poff_r  <= poff_nxt;
      ptemp_r <= ptemp_nxt;
      psq_r   <= psq_nxt;
      d1_s2_r <= d1_s1_r;
    end
  end

  // Stage 3: first-order sensitivity, offset and temperature difference.
  // The scaled temperature product is below 2^40 in magnitude.
  logic [39:0]        sens1_r, sens1_nxt;
  logic [40:0]        off1_s3_r, off1_nxt;
  logic signed [17:0] x_r;
  logic [16:0]        t2_r;
  logic               low_s3_r, vlow_s3_r;
  logic [23:0]        d1_s3_r;

  assign sens1_nxt = {9'b0, cal.pressure_sensitivity, 15'b0}
                   + {{6{psens_r[41]}}, psens_r[41:8]};
  assign off1_nxt  = {9'b0, cal.pressure_offset, 16'b0}
                   + {{6{poff_r[41]}}, poff_r[41:7]};

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sens1_r   <= sens1_nxt;
      off1_s3_r <= off1_nxt;
      x_r       <= $signed(ptemp_r[40:23]);
      t2_r      <= psq_r[47:31];
      low_s3_r  <= ptemp_r[41];
      vlow_s3_r <= $signed(ptemp_r[40:23]) < baro_comp_pkg::X_VLOW;
      d1_s3_r   <= d1_s2_r;
    end
  end

  // Stage 4: squares of the temperature relative to both break points,
  // and the final temperature. The result always fits the output range.
  logic signed [35:0] fm;
  logic signed [18:0] y;
  logic signed [37:0] gm;
  logic [19:0]        temp_nxt;
  logic [34:0]        f_r;
  logic [33:0]        g_r;
  logic [19:0]        temp_s4_r;
  logic [39:0]        sens1_s4_r;
  logic [40:0]        off1_s4_r;
  logic               low_s4_r, vlow_s4_r;
  logic [23:0]        d1_s4_r;

  assign fm       = x_r * x_r;
  assign y        = $signed({x_r[17], x_r}) + baro_comp_pkg::VLOW_BIAS;
  assign gm       = y * y;
  assign temp_nxt = {{2{x_r[17]}}, x_r} + baro_comp_pkg::TEMP_REF
                  - {3'b0, (low_s3_r ? t2_r : 17'd0)};

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      f_r        <= fm[34:0];
      g_r        <= gm[33:0];
      temp_s4_r  <= temp_nxt;
      sens1_s4_r <= sens1_r;
      off1_s4_r  <= off1_s3_r;
      low_s4_r   <= low_s3_r;
      vlow_s4_r  <= vlow_s3_r;
      d1_s4_r    <= d1_s3_r;
    end
  end

  // Stage 5: second-order offset and sensitivity terms by shift and add.
  logic [37:0] f5, g7, g11;
  logic [38:0] off2_r, off2_nxt;
  logic [37:0] sens2_r, sens2_nxt;
  logic [39:0] sens1_s5_r;
  logic [40:0] off1_s5_r;
  logic        low_s5_r;
  logic [19:0] temp_s5_r;
  logic [23:0] d1_s5_r;

  assign f5  = {3'b0, f_r} + {1'b0, f_r, 2'b0};
  assign g7  = {1'b0, g_r, 3'b0} - {4'b0, g_r};
  assign g11 = {1'b0, g_r, 3'b0} + {3'b0, g_r, 1'b0} + {4'b0, g_r};

  assign off2_nxt  = {2'b0, f5[37:1]} + {1'b0, (vlow_s4_r ? g7 : 38'd0)};
  assign sens2_nxt = {2'b0, f5[37:2]} + {1'b0, (vlow_s4_r ? g11[37:1] : 37'd0)};

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      off2_r     <= off2_nxt;
      sens2_r    <= sens2_nxt;
      sens1_s5_r <= sens1_s4_r;
      off1_s5_r  <= off1_s4_r;
      low_s5_r   <= low_s4_r;
      temp_s5_r  <= temp_s4_r;
      d1_s5_r    <= d1_s4_r;
    end
  end

  // Stage 6: apply the second-order terms below the reference temperature.
  logic [39:0] sens_r, sens_nxt;
  logic [40:0] off_s6_r, off_nxt;
  logic [19:0] temp_s6_r;
  logic [23:0] d1_s6_r;

  assign sens_nxt = sens1_s5_r - (low_s5_r ? {2'b0, sens2_r} : 40'd0);
  assign off_nxt  = off1_s5_r - (low_s5_r ? {2'b0, off2_r} : 41'd0);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sens_r    <= sens_nxt;
      off_s6_r  <= off_nxt;
      temp_s6_r <= temp_s5_r;
      d1_s6_r   <= d1_s5_r;
    end
  end

  // Stage 7: pressure times sensitivity as two partial products.
  logic [43:0]        pp_lo_r, pp_lo_nxt;
  logic signed [44:0] pp_hi_r, pp_hi_nxt;
  logic [40:0]        off_s7_r;
  logic [19:0]        temp_s7_r;

  assign pp_lo_nxt = d1_s6_r * sens_r[19:0];
  assign pp_hi_nxt = $signed({1'b0, d1_s6_r}) * $signed(sens_r[39:20]);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      pp_lo_r   <= pp_lo_nxt;
      pp_hi_r   <= pp_hi_nxt;
      off_s7_r  <= off_s6_r;
      temp_s7_r <= temp_s6_r;
    end
  end

  // Stage 8: combine the partial products; the upper one fits 44 bits.
  logic [63:0] prod_r, prod_nxt;
  logic [40:0] off_s8_r;
  logic [19:0] temp_s8_r;

  assign prod_nxt = {pp_hi_r[43:0], 20'b0} + {20'b0, pp_lo_r};

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      prod_r    <= prod_nxt;
      off_s8_r  <= off_s7_r;
      temp_s8_r <= temp_s7_r;
    end
  end

  // Stage 9: remove the offset and scale down to pascal.
  logic [43:0] q;
  logic [28:0] pw_r;
  logic [19:0] temp_s9_r;

  assign q = {prod_r[63], prod_r[63:21]} - {{3{off_s8_r[40]}}, off_s8_r};

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      pw_r      <= q[43:15];
      temp_s9_r <= temp_s8_r;
    end
  end

  // Stage 10: saturate the pressure into the output register.
  logic [27:0] pres_nxt;
  logic [27:0] out_pres_r;
  logic [19:0] out_temp_r;

  always_comb begin
    if (pw_r[28] != pw_r[27]) begin
      pres_nxt = pw_r[28] ? baro_comp_pkg::PRES_MIN : baro_comp_pkg::PRES_MAX;
    end else begin
      pres_nxt = pw_r[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      out_pres_r <= pres_nxt;
      out_temp_r <= temp_s9_r;
    end
  end

  assign out_tvalid = vld_r[baro_comp_pkg::NSTG];
  assign out_tdata  = {out_pres_r, out_temp_r};

endmodule

// File: tb/baro_pressure_temp_compensation_core_test.sv
// ============================================================================
// Barometric compensation core testbench
// Drives raw temperature and pressure pairs into the compensation core under
// several calibration sets, predicts each result with a 64-bit model of the
// second-order correction unless a directed row gives it, and checks the
// results in order while both stream sides idle and stall at random.
// ============================================================================
module baro_pressure_temp_compensation_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Raw sample and calibration word types.
  typedef logic [baro_comp_pkg::RAW_W-1:0] raw_word_t;
  typedef logic [baro_comp_pkg::CAL_W-1:0] cal_word_t;

  // Indexes that no register answers to; writes to them must be ignored.
  localparam logic [2:0] IDX_UNUSED_6 = 3'd6;
  localparam logic [2:0] IDX_UNUSED_7 = 3'd7;

  // Temperature break points and output limits.
  localparam longint T_REF_CENTI  = 2000;
  localparam longint T_VLOW_CENTI = -1500;
  localparam longint TEMP_LO      = -524288;
  localparam longint TEMP_HI      = 524287;
  localparam longint PRES_LO      = -134217728;
  localparam longint PRES_HI      = 134217727;

  localparam logic [23:0] RAW_MAX    = 24'hFFFFFF;
  localparam int          RAND_PHASES = 6;
  localparam int          PHASE_ITEMS = 75;
  localparam int          HOLD_CYCLES = 80;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [baro_comp_pkg::TEMP_W-1:0] temp;
    logic signed [baro_comp_pkg::PRES_W-1:0] pres;
  } baro_result_t;

  // One row of the directed stimulus: a calibration write or a sample pair.
  typedef struct {
    bit                                      is_cfg;
    logic [2:0]                              idx;
    cal_word_t                               data;
    raw_word_t                               raw_t;
    raw_word_t                               raw_p;
    bit                                      typed;
    logic signed [baro_comp_pkg::TEMP_W-1:0] temp;
    logic signed [baro_comp_pkg::PRES_W-1:0] pres;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [23:0] raw_temperature, [47:24] raw_pressure
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [19:0] temperature_centideg, [47:20] pressure_pascal
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  baro_comp_pkg::calib_t calib;
  baro_result_t    pending_results[$];
  directed_row_t   directed_table[$];
  int              fail_count;
  int              cycle_count;
  int              burst_left;
  bit              gapless;
  bit              sending;
  bit              cfg_open;
  bit              hold_start;

  baro_pressure_temp_compensation_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Second-order compensation of one sample pair under the current calibration.
  function automatic baro_result_t compensate(input raw_word_t raw_t,
                                              input raw_word_t raw_p);
    longint d2, d1, dt, sens, off, temp, t2, f, f2, off2, sens2, p;
    baro_result_t res;
    d2   = longint'({40'd0, raw_t});
    d1   = longint'({40'd0, raw_p});
    dt   = d2 - longint'({48'd0, calib.reference_temperature}) * 256;
    sens = longint'({48'd0, calib.pressure_sensitivity}) * 32768
         + ((longint'({48'd0, calib.sensitivity_temp_coeff}) * dt) >>> 8);
    off  = longint'({48'd0, calib.pressure_offset}) * 65536
         + ((longint'({48'd0, calib.offset_temp_coeff}) * dt) >>> 7);
    temp = T_REF_CENTI + ((dt * longint'({48'd0, calib.temperature_coeff})) >>> 23);
    // Cold branch; both tests look at the first-order temperature.
    if (temp < T_REF_CENTI) begin
      t2    = (dt * dt) >>> 31;
      f     = (temp - T_REF_CENTI) * (temp - T_REF_CENTI);
      off2  = (5 * f) >>> 1;
      sens2 = (5 * f) >>> 2;
      if (temp < T_VLOW_CENTI) begin
        f2    = (temp - T_VLOW_CENTI) * (temp - T_VLOW_CENTI);
        off2  = off2 + 7 * f2;
        sens2 = sens2 + ((11 * f2) >>> 1);
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = ((((d1 * sens) >>> 21) - off) >>> 15);
    if (temp < TEMP_LO) temp = TEMP_LO;
    if (temp > TEMP_HI) temp = TEMP_HI;
    if (p < PRES_LO) p = PRES_LO;
    if (p > PRES_HI) p = PRES_HI;
    res.temp = temp[baro_comp_pkg::TEMP_W-1:0];
    res.pres = p[baro_comp_pkg::PRES_W-1:0];
    return res;
  endfunction

  function automatic void row_cfg(input logic [2:0] idx, input cal_word_t data);
    directed_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    directed_table.push_back(r);
  endfunction

  function automatic void row_item(input raw_word_t raw_t,
                                   input raw_word_t raw_p, input bit typed,
                                   input int temp, input int pres);
    directed_row_t r;
    r       = '{default: '0};
    r.raw_t = raw_t;
    r.raw_p = raw_p;
    r.typed = typed;
    r.temp  = temp[baro_comp_pkg::TEMP_W-1:0];
    r.pres  = pres[baro_comp_pkg::PRES_W-1:0];
    directed_table.push_back(r);
  endfunction

  // Stop offering samples and wait until every expected result is back.
  task automatic quiesce();
    if (sending) begin
      in_tvalid <= 1'b0;
      sending = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one calibration register while the core is idle.
  task automatic write_calib(input logic [2:0] idx, input cal_word_t data);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_open = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (baro_comp_pkg::reg_idx_t'(idx))
      baro_comp_pkg::REG_PRESSURE_SENSITIVITY:   calib.pressure_sensitivity   = data;
      baro_comp_pkg::REG_PRESSURE_OFFSET:        calib.pressure_offset        = data;
      baro_comp_pkg::REG_SENSITIVITY_TEMP_COEFF: calib.sensitivity_temp_coeff = data;
      baro_comp_pkg::REG_OFFSET_TEMP_COEFF:      calib.offset_temp_coeff      = data;
      baro_comp_pkg::REG_REFERENCE_TEMPERATURE:  calib.reference_temperature  = data;
      baro_comp_pkg::REG_TEMPERATURE_COEFF:      calib.temperature_coeff      = data;
      default: ;
    endcase
  endtask

  task automatic write_calib_set(input baro_comp_pkg::calib_t c);
    write_calib(baro_comp_pkg::REG_PRESSURE_SENSITIVITY,   c.pressure_sensitivity);
    write_calib(baro_comp_pkg::REG_PRESSURE_OFFSET,        c.pressure_offset);
    write_calib(baro_comp_pkg::REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
    write_calib(baro_comp_pkg::REG_OFFSET_TEMP_COEFF,      c.offset_temp_coeff);
    write_calib(baro_comp_pkg::REG_REFERENCE_TEMPERATURE,  c.reference_temperature);
    write_calib(baro_comp_pkg::REG_TEMPERATURE_COEFF,      c.temperature_coeff);
  endtask

  // Offer one sample pair; the sender works in bursts with random gaps.
  task automatic send_sample(input raw_word_t raw_t, input raw_word_t raw_p,
                             input baro_result_t expected);
    int gap;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || gapless) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_p, raw_t};
    sending = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(expected);
  endtask

  // Random raw temperature, weighted toward the reference and the cold side.
  function automatic raw_word_t pick_raw_temp();
    int base, v;
    base = int'(calib.reference_temperature) * 256;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 24'hFFFFFF);
      4, 5, 6:    v = base + int'($urandom_range(0, 2097152)) - 1048576;
      7, 8:       v = base - int'($urandom_range(0, base));
      default:    v = $urandom_range(0, 1) ? 0 : 24'hFFFFFF;
    endcase
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[baro_comp_pkg::RAW_W-1:0];
  endfunction

  function automatic raw_word_t pick_raw_pres();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_MAX;
      default: return raw_word_t'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic cal_word_t pick_word(input int mode);
    case (mode)
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return cal_word_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Receiver: stretches of readiness patterns, plus a long hold-off on request.
  initial begin
    int hold_cnt, stretch_left, stretch_mode;
    hold_cnt     = 0;
    stretch_left = 0;
    stretch_mode = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (hold_start) begin
        hold_start = 1'b0;
        hold_cnt   = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_mode = $urandom_range(0, 2);
          stretch_left = $urandom_range(5, 40);
        end
        stretch_left--;
        case (stretch_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    baro_result_t exp_res;
    logic signed [baro_comp_pkg::TEMP_W-1:0] got_t;
    logic signed [baro_comp_pkg::PRES_W-1:0] got_p;
    if (rst_n && out_tvalid && out_tready) begin
      got_t = out_tdata[19:0];
      got_p = out_tdata[47:20];
      if (pending_results.size() == 0) begin
        $error("unexpected result: temperature_centideg %0d, pressure_pascal %0d",
               got_t, got_p);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got_t !== exp_res.temp) begin
          $error("temperature_centideg: expected %0d, actual %0d", exp_res.temp, got_t);
          fail_count++;
        end
        if (got_p !== exp_res.pres) begin
          $error("pressure_pascal: expected %0d, actual %0d", exp_res.pres, got_p);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed stimulus: reset calibration, ignored indexes, extremes and both
  // cold branches with their break points.
  task automatic build_directed_table();
    // Calibration at reset: temperature sits at 20.00 C and pressure at zero.
    row_item(24'd0, 24'd0, 1'b1, 2000, 0);
    row_item(RAW_MAX, RAW_MAX, 1'b1, 2000, 0);
    row_cfg(IDX_UNUSED_6, 16'hFFFF);
    row_cfg(IDX_UNUSED_7, 16'hFFFF);
    row_item(24'h123456, 24'hABCDEF, 1'b1, 2000, 0);
    // Every word at its maximum.
    row_cfg(baro_comp_pkg::REG_PRESSURE_SENSITIVITY,   16'hFFFF);
    row_cfg(baro_comp_pkg::REG_PRESSURE_OFFSET,        16'hFFFF);
    row_cfg(baro_comp_pkg::REG_SENSITIVITY_TEMP_COEFF, 16'hFFFF);
    row_cfg(baro_comp_pkg::REG_OFFSET_TEMP_COEFF,      16'hFFFF);
    row_cfg(baro_comp_pkg::REG_REFERENCE_TEMPERATURE,  16'hFFFF);
    row_cfg(baro_comp_pkg::REG_TEMPERATURE_COEFF,      16'hFFFF);
    row_item(24'd0, 24'd0, 1'b0, 0, 0);
    row_item(RAW_MAX, RAW_MAX, 1'b0, 0, 0);
    row_item(24'd0, RAW_MAX, 1'b0, 0, 0);
    row_item(RAW_MAX, 24'd0, 1'b0, 0, 0);
    row_item(24'hFFFF00, 24'h800000, 1'b0, 0, 0);
    // Typical factory words; warm, at and just below 20.00 C, cold and very cold.
    row_cfg(baro_comp_pkg::REG_PRESSURE_SENSITIVITY,   16'd40127);
    row_cfg(baro_comp_pkg::REG_PRESSURE_OFFSET,        16'd36924);
    row_cfg(baro_comp_pkg::REG_SENSITIVITY_TEMP_COEFF, 16'd23317);
    row_cfg(baro_comp_pkg::REG_OFFSET_TEMP_COEFF,      16'd23282);
    row_cfg(baro_comp_pkg::REG_REFERENCE_TEMPERATURE,  16'd33464);
    row_cfg(baro_comp_pkg::REG_TEMPERATURE_COEFF,      16'd28312);
    row_item(24'd8569150, 24'd9085466, 1'b0, 0, 0);
    row_item(24'd8566784, 24'd9085466, 1'b0, 0, 0);
    row_item(24'd8566783, 24'd9085466, 1'b0, 0, 0);
    row_item(24'd8066784, 24'd9085466, 1'b0, 0, 0);
    row_item(24'd7366784, 24'd9085466, 1'b0, 0, 0);
    // Mixed extremes; the raw minimum drives the largest corrections.
    row_cfg(baro_comp_pkg::REG_PRESSURE_OFFSET,        16'h0000);
    row_cfg(baro_comp_pkg::REG_SENSITIVITY_TEMP_COEFF, 16'h0000);
    row_cfg(baro_comp_pkg::REG_OFFSET_TEMP_COEFF,      16'hFFFF);
    row_cfg(baro_comp_pkg::REG_REFERENCE_TEMPERATURE,  16'hFFFF);
    row_cfg(baro_comp_pkg::REG_TEMPERATURE_COEFF,      16'hFFFF);
    row_item(24'd0, RAW_MAX, 1'b0, 0, 0);
    row_item(RAW_MAX, RAW_MAX, 1'b0, 0, 0);
  endtask

  initial begin
    baro_result_t          exp_res;
    baro_comp_pkg::calib_t next_cal;
    raw_word_t             rt, rp;
    int                    mode;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    calib       = '0;
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = 0;
    gapless     = 1'b0;
    sending     = 1'b0;
    cfg_open    = 1'b0;
    hold_start  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    build_directed_table();
    foreach (directed_table[i]) begin
      if (directed_table[i].is_cfg) begin
        write_calib(directed_table[i].idx, directed_table[i].data);
      end else begin
        if (directed_table[i].typed) begin
          exp_res.temp = directed_table[i].temp;
          exp_res.pres = directed_table[i].pres;
        end else begin
          exp_res = compensate(directed_table[i].raw_t, directed_table[i].raw_p);
        end
        send_sample(directed_table[i].raw_t, directed_table[i].raw_p, exp_res);
      end
    end

    // Random phases, each under a fresh calibration set.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = (ph == 0) ? 1 : (ph == 1) ? 2 : 3;
      next_cal.pressure_sensitivity   = pick_word(mode);
      next_cal.pressure_offset        = pick_word(mode);
      next_cal.sensitivity_temp_coeff = pick_word(mode);
      next_cal.offset_temp_coeff      = pick_word(mode);
      next_cal.reference_temperature  = pick_word(mode);
      next_cal.temperature_coeff      = pick_word(mode);
      write_calib_set(next_cal);
      if ($urandom_range(0, 1))
        write_calib($urandom_range(0, 1) ? IDX_UNUSED_6 : IDX_UNUSED_7,
                    cal_word_t'($urandom_range(0, 16'hFFFF)));
      // One phase runs gapless against a long receiver hold-off.
      gapless = (ph == 2);
      if (gapless) hold_start = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rt = pick_raw_temp();
        rp = pick_raw_pres();
        send_sample(rt, rp, compensate(rt, rp));
      end
      gapless = 1'b0;
    end

    // Drain and finish.
    quiesce();
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
